// File: hdl/dts_pkg.sv
`timescale 1ns / 1ps

package dts_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REM_SCAN,
    ST_DUE_SCAN,
    ST_PICK_SCAN,
    ST_FIRE,
    ST_RESCH_SCAN,
    ST_HEAD_SCAN,
    ST_STATUS
  } state_t;

  localparam logic [1:0] MODE_ADD_ONE  = 2'd0;
  localparam logic [1:0] MODE_ADD_PER  = 2'd1;
  localparam logic [1:0] MODE_REMOVE   = 2'd2;
  localparam logic [1:0] MODE_TICK     = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

endpackage

// File: hdl/dts_ram.sv
`timescale 1ns / 1ps

module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/deadline_timer_scheduler.sv
`timescale 1ns / 1ps
// Deadline timer scheduler: a table of task slots kept in one RAM word per slot
// (task, deadline, period), with slot valid bits in flip-flops.
// A request is taken on a clock edge where start is high and busy is low; busy
// stays high until the last result of that request has been shown.
// Results appear for exactly one cycle with out_valid high; the receiver cannot
// stall them. Fired-task results (out_kind 0) come first in deadline order, and
// every request ends with one status result (out_kind 1, out_last 1).
// Each pass over the table reads one slot a cycle.
// Add: one head pass; a full table goes straight to the status result.
// Remove: a search pass, then a head pass; only the search when not found.
// Tick: a due pass, then one ordering pass per fired task and one more, a
// reschedule pass and a head pass; an empty table goes straight to status.
// Only one request is in work at a time.
// After reset the table is empty and the timer is stopped; no clearing pass.
module deadline_timer_scheduler #(
  parameter int              SLOTS      = 16,
  parameter int              TIME_BITS  = 32,
  parameter longint unsigned MAX_RELOAD = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_task_id,
  input  logic [31:0] in_delay,
  input  logic [31:0] in_now,
  output logic        out_valid,
  output logic        out_kind,
  output logic [7:0]  out_fired_task,
  output logic [1:0]  out_status,
  output logic        out_timer_on,
  output logic        out_timer_restart,
  output logic [15:0] out_reload,
  output logic        out_last
);

  localparam int IW = $clog2(SLOTS);
  localparam int TB = TIME_BITS;
  localparam int RW = 8 + 2 * TB;
  localparam logic [15:0] CAP = (MAX_RELOAD < 64'd65535) ? MAX_RELOAD[15:0] : 16'hFFFF;

  dts_pkg::state_t state_r, state_nxt;
  logic [IW:0]     cnt_r, cnt_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt, due_r, due_nxt, done_r, done_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   bidx_r, bidx_nxt;
  logic [TB-1:0]   bdl_r, bdl_nxt;
  logic [7:0]      btask_r, btask_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            restart_r, restart_nxt, ton_r, ton_nxt;
  logic [TB-1:0]   head_r, head_nxt;
  logic [7:0]      tid_r;
  logic [TB-1:0]   now_r;

  logic            we;
  logic [IW-1:0]   waddr, p;
  logic [RW-1:0]   wdata, rdata;
  logic [7:0]      q_task;
  logic [TB-1:0]   q_dl, q_per;
  logic            proc, last_cyc, cand, take, accept, full;
  logic [IW-1:0]   free_idx;
  logic [TB-1:0]   diff, rl;

  dts_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  assign q_task   = rdata[RW-1 -: 8];
  assign q_dl     = rdata[2*TB-1 -: TB];
  assign q_per    = rdata[TB-1:0];
  assign p        = IW'(cnt_r - 1'b1);
  assign proc     = (cnt_r != '0);
  assign last_cyc = (cnt_r == (IW+1)'(SLOTS));
  assign busy     = (state_r != dts_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign full     = &valid_r;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IW'(i);
    end
  end

  // Earliest-deadline search shared by the remove, pick and head passes;
  // a strict compare keeps the lowest slot on equal deadlines.
  always_comb begin
    case (state_r)
      dts_pkg::ST_REM_SCAN:  cand = valid_r[p] && (q_task == tid_r);
      dts_pkg::ST_PICK_SCAN: cand = due_r[p] && !done_r[p];
      dts_pkg::ST_HEAD_SCAN: cand = valid_r[p];
      default:               cand = 1'b0;
    endcase
    take = proc && cand && (!found_r || (q_dl < bdl_r));
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = (cnt_r < (IW+1)'(SLOTS)) ? cnt_r + 1'b1 : cnt_r;
    valid_nxt   = valid_r;
    due_nxt     = due_r;
    done_nxt    = done_r;
    found_nxt   = found_r || take;
    bidx_nxt    = take ? p : bidx_r;
    bdl_nxt     = take ? q_dl : bdl_r;
    btask_nxt   = take ? q_task : btask_r;
    status_nxt  = status_r;
    restart_nxt = restart_r;
    ton_nxt     = ton_r;
    head_nxt    = head_r;
    we          = 1'b0;
    waddr       = free_idx;
    wdata       = {in_task_id, TB'(in_now) + TB'(in_delay),
                   (in_mode == dts_pkg::MODE_ADD_PER) ? TB'(in_delay) : TB'(0)};

    unique case (state_r)
      dts_pkg::ST_IDLE: begin
        cnt_nxt   = '0;
        found_nxt = 1'b0;
        if (accept) begin
          status_nxt  = dts_pkg::STAT_OK;
          restart_nxt = 1'b0;
          case (in_mode) inside
            dts_pkg::MODE_ADD_ONE, dts_pkg::MODE_ADD_PER: begin
              if (full) begin
                status_nxt = dts_pkg::STAT_FULL;
                state_nxt  = dts_pkg::ST_STATUS;
              end else begin
                we                  = 1'b1;
                valid_nxt[free_idx] = 1'b1;
                state_nxt           = dts_pkg::ST_HEAD_SCAN;
              end
            end
            dts_pkg::MODE_REMOVE: state_nxt = dts_pkg::ST_REM_SCAN;
            default: begin
              state_nxt = (|valid_r) ? dts_pkg::ST_DUE_SCAN : dts_pkg::ST_STATUS;
            end
          endcase
        end
      end
      dts_pkg::ST_REM_SCAN: begin
        if (last_cyc) begin
          cnt_nxt = '0;
          if (!found_nxt) begin
            status_nxt = dts_pkg::STAT_NOTFOUND;
            state_nxt  = dts_pkg::ST_STATUS;
          end else begin
            valid_nxt[bidx_nxt] = 1'b0;
            found_nxt           = 1'b0;
            state_nxt           = dts_pkg::ST_HEAD_SCAN;
          end
        end
      end
      dts_pkg::ST_DUE_SCAN: begin
        if (proc) due_nxt[p] = valid_r[p] && (q_dl <= now_r);
        if (last_cyc) begin
          cnt_nxt   = '0;
          done_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = dts_pkg::ST_PICK_SCAN;
        end
      end
      dts_pkg::ST_PICK_SCAN: begin
        if (last_cyc) begin
          cnt_nxt   = '0;
          state_nxt = found_nxt ? dts_pkg::ST_FIRE : dts_pkg::ST_RESCH_SCAN;
        end
      end
      dts_pkg::ST_FIRE: begin
        done_nxt[bidx_r] = 1'b1;
        cnt_nxt          = '0;
        found_nxt        = 1'b0;
        state_nxt        = dts_pkg::ST_PICK_SCAN;
      end
      dts_pkg::ST_RESCH_SCAN: begin
        // The slot read in the previous cycle is written back while the next is read.
        if (proc && due_r[p]) begin
          if (q_per != '0) begin
            we    = 1'b1;
            waddr = p;
            wdata = {q_task, now_r + q_per, q_per};
          end else begin
            valid_nxt[p] = 1'b0;
          end
        end
        if (last_cyc) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = dts_pkg::ST_HEAD_SCAN;
        end
      end
      dts_pkg::ST_HEAD_SCAN: begin
        if (last_cyc) begin
          cnt_nxt   = '0;
          state_nxt = dts_pkg::ST_STATUS;
          if (!found_nxt) begin
            ton_nxt = 1'b0;
          end else if ((bdl_nxt != head_r) || !ton_r) begin
            ton_nxt     = 1'b1;
            restart_nxt = 1'b1;
            head_nxt    = bdl_nxt;
          end
        end
      end
      dts_pkg::ST_STATUS: begin
        state_nxt = dts_pkg::ST_IDLE;
      end
      default: state_nxt = dts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dts_pkg::ST_IDLE;
      cnt_r     <= '0;
      valid_r   <= '0;
      due_r     <= '0;
      done_r    <= '0;
      found_r   <= 1'b0;
      status_r  <= dts_pkg::STAT_OK;
      restart_r <= 1'b0;
      ton_r     <= 1'b0;
      head_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      valid_r   <= valid_nxt;
      due_r     <= due_nxt;
      done_r    <= done_nxt;
      found_r   <= found_nxt;
      status_r  <= status_nxt;
      restart_r <= restart_nxt;
      ton_r     <= ton_nxt;
      head_r    <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bidx_r  <= bidx_nxt;
    bdl_r   <= bdl_nxt;
    btask_r <= btask_nxt;
    if (accept) begin
      tid_r  <= in_task_id;
      now_r  <= TB'(in_now);
    end
  end

  always_comb begin
    diff = head_r - now_r;
    rl   = ((head_r > now_r) && (diff > TB'(1))) ? diff : TB'(1);
    if (rl > TB'(CAP)) rl = TB'(CAP);
  end

  logic is_status;
  assign is_status = (state_r == dts_pkg::ST_STATUS);

  assign out_valid         = is_status || (state_r == dts_pkg::ST_FIRE);
  assign out_kind          = is_status ? dts_pkg::KIND_STATUS : dts_pkg::KIND_FIRED;
  assign out_fired_task    = is_status ? 8'd0 : btask_r;
  assign out_status        = is_status ? status_r : dts_pkg::STAT_OK;
  assign out_timer_on      = is_status && ton_r;
  assign out_timer_restart = is_status && restart_r;
  assign out_reload        = (is_status && ton_r) ? rl[15:0] : 16'd0;
  assign out_last          = is_status;

endmodule

// File: verif/deadline_timer_scheduler_test.sv
`timescale 1ns / 1ps

module deadline_timer_scheduler_test;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic        kind;
    logic [7:0]  fired_task;
    logic [1:0]  status;
    logic        timer_on;
    logic        timer_restart;
    logic [15:0] reload;
    logic        last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = dts_pkg::MODE_TICK;
  logic [7:0]  in_task_id = '0;
  logic [31:0] in_delay = '0;
  logic [31:0] in_now = '0;
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_fired_task;
  logic [1:0]  out_status;
  logic        out_timer_on;
  logic        out_timer_restart;
  logic [15:0] out_reload;
  logic        out_last;

  deadline_timer_scheduler i_dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the task table.
  logic        tbl_valid [NSLOT];
  logic [7:0]  tbl_task [NSLOT];
  logic [31:0] tbl_deadline [NSLOT];
  logic [31:0] tbl_period [NSLOT];
  logic [31:0] cur_head;
  logic        cur_timer_on;

  sched_result_t expected_results[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  sender_gap_pct = 0;
  logic [31:0] clock_ms = 0;

  function automatic bit slot_earlier(int a, int b);
    if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
    return a < b;
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_valid[i] && (best < 0 || slot_earlier(i, best))) best = i;
    return best;
  endfunction

  function automatic bit resync_timer();
    int h;
    h = earliest_slot();
    if (h < 0) begin
      cur_timer_on = 1'b0;
      return 1'b0;
    end
    if (tbl_deadline[h] != cur_head || !cur_timer_on) begin
      cur_timer_on = 1'b1;
      cur_head = tbl_deadline[h];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [15:0] reload_value(logic [31:0] now);
    logic [31:0] v;
    v = 1;
    if (cur_head > now && cur_head - now > 1) v = cur_head - now;
    if (v > 32'd65535) v = 32'd65535;
    return v[15:0];
  endfunction

  function automatic int free_slot_count();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (!tbl_valid[i]) n++;
    return n;
  endfunction

  task automatic predict_request(logic [1:0] mode, logic [7:0] tid, logic [31:0] delay,
                                 logic [31:0] now);
    sched_result_t r;
    logic [1:0] stat;
    bit restart;
    int slot;
    bit due [NSLOT];
    bit done [NSLOT];
    stat = dts_pkg::STAT_OK;
    restart = 1'b0;
    slot = -1;
    if (mode == dts_pkg::MODE_ADD_ONE || mode == dts_pkg::MODE_ADD_PER) begin
      for (int i = 0; i < NSLOT && slot < 0; i++) if (!tbl_valid[i]) slot = i;
      if (slot < 0) stat = dts_pkg::STAT_FULL;
      else begin
        tbl_valid[slot] = 1'b1;
        tbl_task[slot] = tid;
        tbl_deadline[slot] = now + delay;
        tbl_period[slot] = (mode == dts_pkg::MODE_ADD_PER) ? delay : 32'd0;
        restart = resync_timer();
      end
    end else if (mode == dts_pkg::MODE_REMOVE) begin
      for (int i = 0; i < NSLOT; i++)
        if (tbl_valid[i] && tbl_task[i] == tid && (slot < 0 || slot_earlier(i, slot)))
          slot = i;
      if (slot < 0) stat = dts_pkg::STAT_NOTFOUND;
      else begin
        tbl_valid[slot] = 1'b0;
        restart = resync_timer();
      end
    end else if (earliest_slot() >= 0) begin
      for (int i = 0; i < NSLOT; i++) begin
        due[i] = tbl_valid[i] && tbl_deadline[i] <= now;
        done[i] = 1'b0;
      end
      forever begin
        slot = -1;
        for (int i = 0; i < NSLOT; i++)
          if (due[i] && !done[i] && (slot < 0 || slot_earlier(i, slot))) slot = i;
        if (slot < 0) break;
        done[slot] = 1'b1;
        r = '0;
        r.kind = dts_pkg::KIND_FIRED;
        r.fired_task = tbl_task[slot];
        expected_results.push_back(r);
      end
      for (int i = 0; i < NSLOT; i++) begin
        if (!due[i]) continue;
        if (tbl_period[i] != 0) tbl_deadline[i] = now + tbl_period[i];
        else tbl_valid[i] = 1'b0;
      end
      restart = resync_timer();
    end
    r = '0;
    r.kind = dts_pkg::KIND_STATUS;
    r.status = stat;
    r.timer_on = cur_timer_on;
    r.timer_restart = restart;
    r.reload = cur_timer_on ? reload_value(now) : 16'd0;
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  // start stays high after the accepting edge until the next request or an idle
  // cycle lowers it; busy is high by then, so nothing is taken twice.
  task automatic send_request(logic [1:0] mode, logic [7:0] tid, logic [31:0] delay,
                              logic [31:0] now);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_task_id <= tid;
    in_delay <= delay;
    in_now <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(mode, tid, delay, now);
  endtask

  always @(posedge clk) begin
    sched_result_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_kind, out_fired_task, out_status, out_timer_on, out_timer_restart,
              out_reload, out_last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_boundaries();
    send_request(dts_pkg::MODE_TICK, 8'd0, 32'd0, 32'd0);
    send_request(dts_pkg::MODE_REMOVE, 8'd9, 32'd0, 32'd0);
    send_request(dts_pkg::MODE_ADD_ONE, 8'hFF, 32'hFFFF_FFFF, 32'd0);
    send_request(dts_pkg::MODE_ADD_PER, 8'h00, 32'd0, 32'd5);
    send_request(dts_pkg::MODE_ADD_PER, 8'h55, 32'd100000, 32'd5);
    send_request(dts_pkg::MODE_ADD_ONE, 8'hAA, 32'd1, 32'hFFFF_FFFF);
    send_request(dts_pkg::MODE_TICK, 8'd0, 32'd0, 32'd5);
    send_request(dts_pkg::MODE_TICK, 8'd0, 32'd0, 32'd100005);
    send_request(dts_pkg::MODE_REMOVE, 8'h55, 32'd0, 32'd100005);
    send_request(dts_pkg::MODE_REMOVE, 8'hFF, 32'd0, 32'd100005);
    send_request(dts_pkg::MODE_REMOVE, 8'hFF, 32'd0, 32'd100005);
  endtask

  // Fill the table with equal deadlines, overflow it, fire everything, then remove each task id.
  task automatic test_full_table();
    for (int i = 0; i < NSLOT + 2; i++)
      send_request(i[0] ? dts_pkg::MODE_ADD_PER : dts_pkg::MODE_ADD_ONE, 8'(i), 32'd50,
                   32'd1000);
    send_request(dts_pkg::MODE_TICK, 8'd0, 32'd0, 32'd1050);
    send_request(dts_pkg::MODE_TICK, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < NSLOT; i++) send_request(dts_pkg::MODE_REMOVE, 8'(i), 32'd0, 32'd0);
  endtask

  // Mostly adds near the running clock and ticks that advance it.
  task automatic test_random(int count);
    int pick;
    logic [31:0] dly;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0: dly = $urandom();
        1: dly = 0;
        default: dly = $urandom_range(200);
      endcase
      if (pick < 40 && free_slot_count() > 0 || pick < 3)
        send_request(2'($urandom_range(1)),
                     8'($urandom_range(7)) | (pick[0] ? 8'($urandom()) : 8'd0),
                     dly, clock_ms);
      else if (pick < 55)
        send_request(dts_pkg::MODE_REMOVE, pick[1] ? 8'($urandom()) : 8'($urandom_range(7)),
                     $urandom(), clock_ms);
      else if (pick < 58)
        send_request(dts_pkg::MODE_TICK, 8'($urandom()), $urandom(), $urandom());
      else begin
        clock_ms = clock_ms + $urandom_range(60);
        send_request(dts_pkg::MODE_TICK, 8'($urandom()), $urandom(), clock_ms);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_task[i] = '0;
      tbl_deadline[i] = '0;
      tbl_period[i] = '0;
    end
    cur_head = '0;
    cur_timer_on = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_gap_pct = 7;
    test_boundaries();
    test_full_table();
    test_random(170);
    sender_gap_pct = 88;
    test_random(160);
    sender_gap_pct = 0;
    test_random(170);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// File: deadline_timer_scheduler.f
hdl/dts_pkg.sv
hdl/dts_ram.sv
hdl/deadline_timer_scheduler.sv
verif/deadline_timer_scheduler_test.sv
